// ----- hw/rtl/brgqd_pkg.sv -----
// Shared types and constants for the RGGB quad demosaic block.
// Depends on nothing; imported by bayer_rg8_quad_demosaic_unit.
package brgqd_pkg;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // quad queue geometry
  localparam int unsigned QUAD_DEPTH = 4;
  localparam int unsigned QAW        = 2;  // pointer bits
  localparam int unsigned QCW        = 3;  // fill count bits

  // pixel place inside a quad, in raster order
  typedef enum logic [1:0] {
    POS_TL,
    POS_TR,
    POS_BL,
    POS_BR
  } pos_e;

  // one completed quad waiting to be emitted
  typedef struct packed {
    logic [10:0] x0;
    logic [10:0] y0;
    logic        right;
    logic        below;
    logic [7:0]  p00;
    logic [7:0]  p01;
    logic [7:0]  p10;
    logic [7:0]  p11;
  } quad_t;

endpackage

// ----- hw/rtl/bayer_rg8_quad_demosaic_unit.sv -----
// Top level of the RGGB nearest-neighbour quad demosaic.
// Holds the line store banks, the quad stage, the quad queue and the output sequencer.
// Depends on brgqd_pkg.

// Raw RGGB Bayer bytes enter one per beat in raster order; each pixel gets its missing
// colours from its own 2x2 quad (R top left, G on the diagonal, B bottom right). The even
// row of each pair is kept in a line store split into an even-column and an odd-column
// bank, so both top samples of a quad come out of one synchronous read. When a quad's
// last pixel is accepted its pixels are queued and then emitted in raster order with
// their coordinates, one result per output beat, tlast on the final result of that
// input beat. Where an odd width or height cuts a quad, missing colours take the pixel's
// own value and absent pixels are not emitted. Rate: an input beat is taken every cycle
// while the four-entry quad queue has room; the first result of a quad passes the line
// store read and the quad stage registers, then the queue. The single result port sets the
// sustained figure: even rows run at one pixel a cycle while the queue has room, odd rows
// at the pace of the result port (four results per two pixels). No clearing pass after
// reset: store entries not yet written read as don't-care. Alpha is added downstream.
module bayer_rg8_quad_demosaic_unit
  import brgqd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_data_i,

  // raw pixel beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] raw_value
  input  logic        s_axis_tuser,   // [0] frame_start

  // RGB pixel beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [10:0] col, [21:11] row, [29:22] red,
                                      // [37:30] green, [45:38] blue, [47:46] zero
  output logic        m_axis_tlast    // last_of_run
);

  localparam int unsigned WW  = $clog2(MAX_WIDTH);       // column index bits
  localparam int unsigned EW  = $clog2(MAX_WIDTH + 1);   // width value bits
  localparam int unsigned HW  = $clog2(MAX_HEIGHT);      // row index bits
  localparam int unsigned EH  = $clog2(MAX_HEIGHT + 1);  // height value bits
  localparam int unsigned BD  = (MAX_WIDTH + 1) / 2;     // entries per bank
  localparam int unsigned BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int unsigned WID_RST = (MAX_WIDTH  < 2048) ? MAX_WIDTH  : 2048;
  localparam int unsigned HGT_RST = (MAX_HEIGHT < 2048) ? MAX_HEIGHT : 2048;

  // ---------------------------------------------------------------- config
  // Registers keep the effective size: zero or above the maximum means the maximum.
  function automatic logic [EW-1:0] eff_width(logic [11:0] v);
    if (v == 12'd0 || {20'd0, v} > 32'(MAX_WIDTH)) return EW'(MAX_WIDTH);
    return EW'(v);
  endfunction

  function automatic logic [EH-1:0] eff_height(logic [11:0] v);
    if (v == 12'd0 || {20'd0, v} > 32'(MAX_HEIGHT)) return EH'(MAX_HEIGHT);
    return EH'(v);
  endfunction

  logic [EW-1:0] wid_q;
  logic [EH-1:0] hgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q <= EW'(WID_RST);
      hgt_q <= EH'(HGT_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  wid_q <= eff_width(cfg_data_i);
        REG_FRAME_HEIGHT: hgt_q <= eff_height(cfg_data_i);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- position
  logic          in_acc;
  logic [WW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic [7:0]    left_q;
  logic [EW-1:0] c_adj, c_nx;
  logic [EH-1:0] r_adj, r_nx;
  logic          quad_done, right;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    // frame start, then wrap of a position left beyond a shrunk size
    c_adj = s_axis_tuser ? '0 : EW'(col_q);
    r_adj = s_axis_tuser ? '0 : EH'(row_q);
    if (c_adj >= wid_q) begin
      c_adj = '0;
      r_adj = r_adj + EH'(1);
    end
    if (r_adj >= hgt_q) r_adj = '0;

    quad_done = (c_adj[0] || (c_adj + EW'(1)) == wid_q) &&
                (r_adj[0] || (r_adj + EH'(1)) == hgt_q);
    right     = (c_adj | EW'(1)) < wid_q;

    // position of the next beat, wrapping at row and frame end
    c_nx  = c_adj + EW'(1);
    r_nx  = r_adj + EH'(1);
    col_d = WW'(c_nx);
    row_d = HW'(r_adj);
    if (c_nx >= wid_q) begin
      col_d = '0;
      row_d = (r_nx >= hgt_q) ? '0 : HW'(r_nx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (in_acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------- line store
  // Even rows write one bank per pixel; odd rows read both banks at the quad's
  // address. A beat either writes or reads, and a read in any later cycle than a write sees
  // the new data, so no forwarding is needed.
  logic [7:0]     mem_even [BD];
  logic [7:0]     mem_odd  [BD];
  logic [BAW-1:0] ls_addr;
  logic           ls_wr, ls_rd;
  logic [7:0]     rd_even_q, rd_odd_q;

  assign ls_addr = BAW'(c_adj >> 1);
  assign ls_wr   = in_acc && !r_adj[0];
  assign ls_rd   = in_acc && r_adj[0] && quad_done;

  always_ff @(posedge clk_i) begin
    if (ls_wr && !c_adj[0]) mem_even[ls_addr] <= s_axis_tdata;
    if (ls_rd) rd_even_q <= mem_even[ls_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ls_wr && c_adj[0]) mem_odd[ls_addr] <= s_axis_tdata;
    if (ls_rd) rd_odd_q <= mem_odd[ls_addr];
  end

  // ---------------------------------------------------------------- quad stage
  logic        s1_vld_q;
  logic [10:0] s1_x0_q, s1_y0_q;
  logic        s1_right_q, s1_below_q;
  logic [7:0]  s1_left_q, s1_cur_q;
  quad_t       push_quad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else         s1_vld_q <= in_acc && quad_done;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && quad_done) begin
      s1_x0_q    <= 11'({c_adj[EW-1:1], 1'b0});
      s1_y0_q    <= 11'({r_adj[EH-1:1], 1'b0});
      s1_right_q <= right;
      s1_below_q <= r_adj[0];   // an even-row completion only happens on a last row
      s1_left_q  <= left_q;
      s1_cur_q   <= s_axis_tdata;
    end
  end

  always_comb begin
    push_quad.x0    = s1_x0_q;
    push_quad.y0    = s1_y0_q;
    push_quad.right = s1_right_q;
    push_quad.below = s1_below_q;
    push_quad.p00   = s1_below_q ? rd_even_q : (s1_right_q ? s1_left_q : s1_cur_q);
    push_quad.p01   = s1_below_q ? rd_odd_q  : s1_cur_q;
    push_quad.p10   = s1_right_q ? s1_left_q : s1_cur_q;
    push_quad.p11   = s1_cur_q;
  end

  // ---------------------------------------------------------------- quad queue
  quad_t          q_mem [QUAD_DEPTH];
  logic [QAW-1:0] q_wr_q, q_rd_q;
  logic [QCW-1:0] q_cnt_q;
  logic           q_pop;
  pos_e           pos_q, pos_nx;
  quad_t          head;
  logic           out_last;
  logic [7:0]     red, green, blue;
  logic [10:0]    out_col, out_row;

  // credit covers the quad still in the stage
  assign s_axis_tready = (q_cnt_q + QCW'(s1_vld_q)) < QCW'(QUAD_DEPTH);

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) q_mem[q_wr_q] <= push_quad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
      pos_q   <= POS_TL;
    end else begin
      if (s1_vld_q) q_wr_q <= q_wr_q + QAW'(1);
      if (q_pop)    q_rd_q <= q_rd_q + QAW'(1);
      q_cnt_q <= q_cnt_q + QCW'(s1_vld_q) - QCW'(q_pop);
      if (m_axis_tvalid && m_axis_tready) pos_q <= q_pop ? POS_TL : pos_nx;
    end
  end

  // ---------------------------------------------------------------- output
  assign head          = q_mem[q_rd_q];
  assign m_axis_tvalid = (q_cnt_q != '0);
  assign q_pop         = m_axis_tvalid && m_axis_tready && out_last;

  always_comb begin
    red = head.p00;
    case (pos_q)
      POS_TL: begin
        green    = head.right ? head.p01 : head.p00;
        blue     = (head.right && head.below) ? head.p11 : head.p00;
        out_last = !head.right && !head.below;
        pos_nx   = head.right ? POS_TR : POS_BL;
      end
      POS_TR: begin
        green    = head.p01;
        blue     = head.below ? head.p11 : head.p01;
        out_last = !head.below;
        pos_nx   = POS_BL;
      end
      POS_BL: begin
        green    = head.p10;
        blue     = head.right ? head.p11 : head.p10;
        out_last = !head.right;
        pos_nx   = POS_BR;
      end
      default: begin
        green    = head.p10;
        blue     = head.p11;
        out_last = 1'b1;
        pos_nx   = POS_TL;
      end
    endcase
    out_col = head.x0 | 11'(pos_q[0]);
    out_row = head.y0 | 11'(pos_q[1]);
  end

  assign m_axis_tdata = {2'b00, blue, green, red, out_row, out_col};
  assign m_axis_tlast = out_last;

  // ---------------------------------------------------------------- checks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= QCW'(QUAD_DEPTH))
    else $error("quad queue over its depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> q_cnt_q < QCW'(QUAD_DEPTH))
    else $error("quad pushed into a full queue");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("result run broken before tlast");

endmodule
